// ===== rtl/pct_pkg.sv =====
// Shared types and constants for the prescaled compare timer.
package pct_pkg;

  localparam logic [15:0] RATE_RESET = 16'd2688;
  localparam logic [8:0]  FULL_PERIOD = 9'h100;

  typedef enum logic [1:0] {
    ACT_SYNC   = 2'd0,
    ACT_ENABLE = 2'd1,
    ACT_TARGET = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  // One access as taken from the input stream.
  typedef struct packed {
    action_t     action;
    logic [31:0] timestamp;
    logic        enable;
    logic [7:0]  target_value;
  } pct_req_t;

  // One result word.
  typedef struct packed {
    logic [3:0] counter_value;
    logic       counter_valid;
  } pct_rsp_t;

  // Command to the shared divider. A short operation divides a 16-bit dividend.
  typedef struct packed {
    logic        start;
    logic        long_op;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [15:0] remainder;
  } div_rsp_t;

endpackage

// ===== rtl/pct_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
module pct_divider
  import pct_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [31:0] quo;
  logic [15:0] rem;
  logic [15:0] divisor;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;

  logic [16:0] shifted;
  logic        fits;

  assign shifted = {rem, quo[31]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem  <= '0;
        divisor <= req.divisor;
        // A short operation places its 16-bit dividend in the top half.
        quo  <= req.long_op ? req.dividend : {req.dividend[15:0], 16'd0};
        cnt  <= req.long_op ? 5'd31 : 5'd15;
      end else if (busy) begin
        rem <= fits ? 16'(shifted - {1'b0, divisor}) : shifted[15:0];
        quo <= {quo[30:0], fits};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== rtl/pct_core.sv =====
// Timer state and the sequencer that catches it up through the shared divider.
module pct_core
  import pct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] rate,
  input  logic        req_valid,
  input  pct_req_t    req,
  output logic        req_ready,
  output logic        rsp_valid,
  output pct_rsp_t    rsp,
  input  logic        rsp_ready,
  output div_req_t    div_req,
  input  div_rsp_t    div_rsp
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SYNC,
    S_PDIV,
    S_DDIV,
    S_PHASE,
    S_STAGE,
    S_CMP,
    S_RDIV,
    S_POST,
    S_RESP
  } state_t;

  state_t      state;
  pct_req_t    cur;

  logic [31:0] last_time;
  logic        enabled;
  logic [7:0]  target;
  logic [3:0]  up_count;
  logic [7:0]  stage_count;
  logic [15:0] prescale_phase;

  logic [31:0] delta;
  logic [15:0] ph;
  logic [16:0] sum;
  logic [31:0] quo;
  logic [31:0] ticks;
  logic [8:0]  reach;

  logic [7:0]  stage_gap;
  logic [15:0] period;

  assign stage_gap = target - stage_count;
  assign period    = (target == 8'd0) ? {7'd0, FULL_PERIOD} : {8'd0, target};

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      last_time      <= '0;
      enabled        <= 1'b0;
      target         <= '0;
      up_count       <= '0;
      stage_count    <= '0;
      prescale_phase <= '0;
      div_req.start  <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur <= req;
            rsp <= '0;
            if (req.action == ACT_TARGET) begin
              target <= req.target_value;
              state  <= S_RESP;
            end else if (req.action == ACT_ENABLE && req.enable == enabled) begin
              state <= S_RESP;
            end else begin
              state <= S_SYNC;
            end
          end
        end
        S_SYNC: begin
          delta     <= cur.timestamp - last_time;
          last_time <= cur.timestamp;
          if (rate == 16'd0) begin
            prescale_phase <= '0;
            stage_count    <= '0;
            state          <= S_POST;
          end else if (prescale_phase >= rate) begin
            // The rate changed since the last sync: reduce the stored phase.
            div_req.start    <= 1'b1;
            div_req.long_op  <= 1'b0;
            div_req.dividend <= {16'd0, prescale_phase};
            div_req.divisor  <= rate;
            state            <= S_PDIV;
          end else begin
            ph               <= prescale_phase;
            div_req.start    <= 1'b1;
            div_req.long_op  <= 1'b1;
            div_req.dividend <= cur.timestamp - last_time;
            div_req.divisor  <= rate;
            state            <= S_DDIV;
          end
        end
        S_PDIV: begin
          if (div_rsp.done) begin
            ph               <= div_rsp.remainder;
            div_req.start    <= 1'b1;
            div_req.long_op  <= 1'b1;
            div_req.dividend <= delta;
            div_req.divisor  <= rate;
            state            <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (div_rsp.done) begin
            sum   <= {1'b0, ph} + {1'b0, div_rsp.remainder};
            quo   <= div_rsp.quotient;
            state <= S_PHASE;
          end
        end
        S_PHASE: begin
          if (sum >= {1'b0, rate}) begin
            prescale_phase <= 16'(sum - {1'b0, rate});
            ticks          <= quo + 32'd1;
          end else begin
            prescale_phase <= sum[15:0];
            ticks          <= quo;
          end
          if (!enabled) begin
            stage_count <= '0;
            state       <= S_POST;
          end else begin
            state <= S_STAGE;
          end
        end
        S_STAGE: begin
          reach <= (stage_gap == 8'd0) ? FULL_PERIOD : {1'b0, stage_gap};
          state <= (ticks == 32'd0) ? S_POST : S_CMP;
        end
        S_CMP: begin
          if (ticks < {23'd0, reach}) begin
            stage_count <= stage_count + ticks[7:0];
            state       <= S_POST;
          end else begin
            // First match after reach ticks, then one more every period ticks.
            div_req.start    <= 1'b1;
            div_req.long_op  <= 1'b1;
            div_req.dividend <= ticks - {23'd0, reach};
            div_req.divisor  <= period;
            state            <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (div_rsp.done) begin
            up_count    <= up_count + 4'd1 + div_rsp.quotient[3:0];
            stage_count <= div_rsp.remainder[7:0];
            state       <= S_POST;
          end
        end
        S_POST: begin
          case (cur.action)
            ACT_ENABLE: begin
              stage_count <= '0;
              enabled     <= cur.enable;
              if (cur.enable) begin
                up_count <= '0;
              end
            end
            ACT_READ: begin
              rsp.counter_value <= up_count;
              rsp.counter_valid <= 1'b1;
              up_count          <= '0;
            end
            default: begin
            end
          endcase
          state <= S_RESP;
        end
        S_RESP: begin
          if (rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_RESP);

endmodule

// ===== rtl/prescaled_compare_timer.sv =====
// Top level of the prescaled compare timer: stream ports, register port, result register.
//
// Each input word is one timer access (sync, set enable, write target, read and clear)
// stamped with the absolute cycle time at which it happens. Every accepted word gives
// exactly one result word; only a read carries a counter value, flagged in m_tuser.
// The cycles_per_tick register sits at byte address 0 of the APB port and reads back.
//
// One access is handled at a time. A target write, or a set enable that does not change
// the state, goes from acceptance straight to the result step. Unless the rate is zero, a
// sync runs a long pass of the shared bit-serial divider that splits the elapsed time into
// ticks and phase, plus sequencer steps. A short divider pass comes first after a rate
// change, when the stored phase is reduced, and another long pass follows when the stage
// counter wraps, when the tick count is divided by the compare period.
//
// Reset (synchronous, active high) restores the rate to 2688 and clears all timer state.
// A result waits in the output register while m_tready is low; the next access is
// accepted meanwhile and held in its final step until the register frees.
module prescaled_compare_timer
  import pct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // timestamp[31:0], enable[32], target_value[40:33], zero
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // counter_value[3:0], zero
  output logic        m_tuser,   // counter_valid[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] rate;
  pct_req_t    req;
  pct_rsp_t    rsp;
  logic        rsp_valid;
  logic        rsp_ready;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  pct_rsp_t    out_word;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RATE_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      rate <= pwdata[15:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {16'd0, rate};

  assign req.action       = action_t'(s_tuser);
  assign req.timestamp    = s_tdata[31:0];
  assign req.enable       = s_tdata[32];
  assign req.target_value = s_tdata[40:33];

  pct_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pct_core u_core (
    .clk       (clk),
    .rst       (rst),
    .rate      (rate),
    .req_valid (s_tvalid),
    .req       (req),
    .req_ready (s_tready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .rsp_ready (rsp_ready),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  assign rsp_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rsp_ready) begin
      m_tvalid <= rsp_valid;
      if (rsp_valid) begin
        out_word <= rsp;
      end
    end
  end

  assign m_tdata = {4'd0, out_word.counter_value};
  assign m_tuser = out_word.counter_valid;

endmodule

// ===== rtl/pct_checker.sv =====
// Port-level checks for the prescaled compare timer, bound to the top level.
module pct_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tuser,
  input logic        pready
);

  // A held result word must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // Only a read carries a counter value.
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 8'd0)
    else $error("non-read result carries a counter value");

  // One access at a time: the input closes right after an acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word accepted while busy");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid |-> pready)
    else $error("register port not ready");

endmodule

bind prescaled_compare_timer pct_checker u_pct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .pready   (pready)
);
